// ===== rtl/gdi_pkg.sv =====
// Package: shared types, constants and month tables of the date insight pipeline.
`default_nettype none
package gdi_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned ShYearW = 15;   // year + 400 - a
  localparam int unsigned QuotW   = 8;    // quotient by 100
  localparam int unsigned SumW    = 16;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned ToYearW = 9;

  // Reciprocal of 100: (x * Recip100) >> Recip100Shift is exact for x < 43691
  localparam int unsigned RecipW        = 13;
  localparam int unsigned Recip100Shift = 19;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;

  localparam logic [ShYearW-1:0] CycleYears = 15'd400;
  localparam logic [MonthW-1:0]  MonthJan   = 4'd1;
  localparam logic [MonthW-1:0]  MonthFeb   = 4'd2;
  localparam logic [WdayW-1:0]   WdaySun    = 3'd0;
  localparam logic [WdayW-1:0]   WdaySat    = 3'd6;
  localparam logic [WdayW-1:0]   WeekLen    = 3'd7;

  // Stage 1 beat: inputs plus shifted year and quotients by 100
  typedef struct packed {
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [ShYearW-1:0] ys;
    logic [QuotW-1:0]   qs;
    logic [QuotW-1:0]   qy;
  } s1_t;

  // Stage 2 beat: weekday sum and leap flag
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic              leap;
    logic [SumW-1:0]   sum;
  } s2_t;

  // floor(31 * m / 12) with m the month counted from March
  function automatic logic [DayW-1:0] month_offset(input logic [MonthW-1:0] month);
    logic [DayW-1:0] r;
    case (month)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Common-year month length, 0 for a month code outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month);
    logic [DayW-1:0] r;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the months after this one, common year
  function automatic logic [ToYearW-1:0] later_days(input logic [MonthW-1:0] month);
    logic [ToYearW-1:0] r;
    case (month)
      4'd1:    r = 9'd334;
      4'd2:    r = 9'd306;
      4'd3:    r = 9'd275;
      4'd4:    r = 9'd245;
      4'd5:    r = 9'd214;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd153;
      4'd8:    r = 9'd122;
      4'd9:    r = 9'd92;
      4'd10:   r = 9'd61;
      4'd11:   r = 9'd31;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gregorian_date_insights.sv =====
// Top level: Gregorian date insight pipeline (weekday and days remaining).
//
// Usage: drive day_of_month_i, month_number_i and year_number_i and raise
// start_i for one cycle per date. A date is taken at every rising edge with
// start_i high and busy_o low; busy_o is always low, so one date can be
// taken every cycle (one item per clock sustained).
// Each date passes three register stages: the reciprocal multiplies for the
// quotients by 100, the leap flag and weekday sum, then the modulo-7 fold
// and month tables into the output registers. Its result beat appears on
// the result ports once the output registers take it, marked by done_o for
// exactly one cycle; results leave in input order.
// Invalid dates (month outside 1..12, day 0 or past month end) give
// date_valid_o low and all other result fields zero.
// The receiver cannot stall: it must take each beat while done_o is high.
// Reset (rst_ni low, asynchronous) clears the stage valid bits, so no beat
// is in flight afterwards; the data registers are not reset.
`default_nettype none
module gregorian_date_insights (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [gdi_pkg::DayW-1:0]    day_of_month_i,
  input  wire logic [gdi_pkg::MonthW-1:0]  month_number_i,
  input  wire logic [gdi_pkg::YearW-1:0]   year_number_i,
  output logic                             done_o,
  output logic [gdi_pkg::WdayW-1:0]        weekday_o,
  output logic                             is_weekend_o,
  output logic                             is_business_day_o,
  output logic [gdi_pkg::WdayW-1:0]        days_to_week_end_o,
  output logic [gdi_pkg::DayW-1:0]         days_to_month_end_o,
  output logic [gdi_pkg::ToYearW-1:0]      days_to_year_end_o,
  output logic                             date_valid_o
);
  import gdi_pkg::*;

  logic accept;
  logic v1, v2;
  s1_t  b1;
  s2_t  b2;

  // pipeline never stalls
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  gdi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .day_i   (day_of_month_i),
    .month_i (month_number_i),
    .year_i  (year_number_i),
    .valid_o (v1),
    .beat_o  (b1)
  );

  gdi_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .beat_i  (b1),
    .valid_o (v2),
    .beat_o  (b2)
  );

  gdi_finish u_finish (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (v2),
    .beat_i              (b2),
    .done_o              (done_o),
    .weekday_o           (weekday_o),
    .is_weekend_o        (is_weekend_o),
    .is_business_day_o   (is_business_day_o),
    .days_to_week_end_o  (days_to_week_end_o),
    .days_to_month_end_o (days_to_month_end_o),
    .days_to_year_end_o  (days_to_year_end_o),
    .date_valid_o        (date_valid_o)
  );
endmodule
`default_nettype wire

// ===== rtl/gdi_front.sv =====
// Stage 1: shifted year and quotients by 100 through reciprocal multiplies.
`default_nettype none
module gdi_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [gdi_pkg::DayW-1:0]  day_i,
  input  wire logic [gdi_pkg::MonthW-1:0] month_i,
  input  wire logic [gdi_pkg::YearW-1:0] year_i,
  output logic                           valid_o,
  output gdi_pkg::s1_t                   beat_o
);
  import gdi_pkg::*;

  logic                            a_jf;
  logic [ShYearW-1:0]              ys;
  logic [ShYearW+RecipW-1:0]       prod_s;
  logic [YearW+RecipW-1:0]         prod_y;
  s1_t                             beat_d, beat_q;
  logic                            valid_q;

  // January and February belong to the previous shifted year
  always_comb begin
    a_jf   = (month_i <= MonthFeb);
    ys     = {1'b0, year_i} + CycleYears - {{(ShYearW-1){1'b0}}, a_jf};
    prod_s = {{RecipW{1'b0}}, ys} * {{ShYearW{1'b0}}, Recip100};
    prod_y = {{RecipW{1'b0}}, year_i} * {{YearW{1'b0}}, Recip100};
    beat_d.day   = day_i;
    beat_d.month = month_i;
    beat_d.year  = year_i;
    beat_d.ys    = ys;
    beat_d.qs    = prod_s[Recip100Shift +: QuotW];
    beat_d.qy    = prod_y[Recip100Shift +: QuotW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule
`default_nettype wire

// ===== rtl/gdi_sum.sv =====
// Stage 2: leap-year flag and the shifted-month weekday sum.
`default_nettype none
module gdi_sum (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  gdi_pkg::s1_t      beat_i,
  output logic              valid_o,
  output gdi_pkg::s2_t      beat_o
);
  import gdi_pkg::*;

  logic [YearW-1:0] rem_y;
  s2_t              beat_d, beat_q;
  logic             valid_q;

  always_comb begin
    // year % 100 from the quotient
    rem_y = beat_i.year - ({{(YearW-QuotW){1'b0}}, beat_i.qy} * 14'd100);
    beat_d.day   = beat_i.day;
    beat_d.month = beat_i.month;
    beat_d.leap  = ((beat_i.year[1:0] == 2'd0) && (rem_y != '0)) ||
                   ((rem_y == '0) && (beat_i.qy[1:0] == 2'd0));
    // day + y + y/4 - y/100 + y/400 + floor(31m/12)
    beat_d.sum   = {{(SumW-DayW){1'b0}}, beat_i.day}
                 + {{(SumW-ShYearW){1'b0}}, beat_i.ys}
                 + {{(SumW-ShYearW+2){1'b0}}, beat_i.ys[ShYearW-1:2]}
                 - {{(SumW-QuotW){1'b0}}, beat_i.qs}
                 + {{(SumW-QuotW+2){1'b0}}, beat_i.qs[QuotW-1:2]}
                 + {{(SumW-DayW){1'b0}}, month_offset(beat_i.month)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule
`default_nettype wire

// ===== rtl/gdi_finish.sv =====
// Stage 3: weekday modulo 7, validity and remaining-day counts into output registers.
`default_nettype none
module gdi_finish (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  gdi_pkg::s2_t                      beat_i,
  output logic                              done_o,
  output logic [gdi_pkg::WdayW-1:0]         weekday_o,
  output logic                              is_weekend_o,
  output logic                              is_business_day_o,
  output logic [gdi_pkg::WdayW-1:0]         days_to_week_end_o,
  output logic [gdi_pkg::DayW-1:0]          days_to_month_end_o,
  output logic [gdi_pkg::ToYearW-1:0]       days_to_year_end_o,
  output logic                              date_valid_o
);
  import gdi_pkg::*;

  logic [5:0]         fold1;
  logic [3:0]         fold2;
  logic [WdayW-1:0]   wd;
  logic [DayW-1:0]    len;
  logic               ok;
  logic [DayW-1:0]    to_month;
  logic [ToYearW-1:0] to_year;
  logic [WdayW-1:0]   wday_d, wday_q, wend_d, wend_q;
  logic               wkend_d, wkend_q, biz_d, biz_q, ok_q;
  logic [DayW-1:0]    tom_q;
  logic [ToYearW-1:0] toy_q;
  logic               done_q;

  always_comb begin
    // mod 7 by folding octal digits (8 = 1 mod 7)
    fold1 = {3'b0, beat_i.sum[2:0]} + {3'b0, beat_i.sum[5:3]} + {3'b0, beat_i.sum[8:6]}
          + {3'b0, beat_i.sum[11:9]} + {3'b0, beat_i.sum[14:12]}
          + {5'b0, beat_i.sum[15]};
    fold2 = {1'b0, fold1[5:3]} + {1'b0, fold1[2:0]};
    if (fold2 >= {1'b0, WeekLen}) begin
      wd = 3'(fold2 - {1'b0, WeekLen});
    end else begin
      wd = fold2[WdayW-1:0];
    end

    // month length and validity
    len = month_len(beat_i.month);
    if ((beat_i.month == MonthFeb) && beat_i.leap) begin
      len = 5'd29;
    end
    ok       = (len != '0) && (beat_i.day != '0) && (beat_i.day <= len);
    to_month = len - beat_i.day;
    to_year  = {{(ToYearW-DayW){1'b0}}, to_month} + later_days(beat_i.month)
             + {{(ToYearW-1){1'b0}}, (beat_i.month == MonthJan) && beat_i.leap};

    // invalid dates give all-zero fields
    wday_d  = ok ? wd : '0;
    wkend_d = ok && ((wd == WdaySun) || (wd == WdaySat));
    biz_d   = ok && !((wd == WdaySun) || (wd == WdaySat));
    wend_d  = (ok && (wd != WdaySun)) ? (WeekLen - wd) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      wday_q  <= wday_d;
      wkend_q <= wkend_d;
      biz_q   <= biz_d;
      wend_q  <= wend_d;
      tom_q   <= ok ? to_month : '0;
      toy_q   <= ok ? to_year : '0;
      ok_q    <= ok;
    end
  end

  assign done_o              = done_q;
  assign weekday_o           = wday_q;
  assign is_weekend_o        = wkend_q;
  assign is_business_day_o   = biz_q;
  assign days_to_week_end_o  = wend_q;
  assign days_to_month_end_o = tom_q;
  assign days_to_year_end_o  = toy_q;
  assign date_valid_o        = ok_q;
endmodule
`default_nettype wire
